@@ sv/bse_pkg.sv @@
// shared constants and types for the bubble sort engine
// no dependencies; imported by bubble_sort_engine, bse_cmp_swap and the testbench
`default_nettype none

package bse_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int DATA_W    = 32;
   localparam int ADDR_W    = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

   typedef enum logic [2:0] {
      S_LOAD,
      S_PASS_INIT,
      S_PASS_LOAD,
      S_PASS_RUN,
      S_PASS_END,
      S_EMIT_RD,
      S_EMIT_CAP,
      S_EMIT_WAIT
   } state_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] lo;
      logic signed [DATA_W-1:0] hi;
   } cmp_out_type;

endpackage

`default_nettype wire

@@ sv/bubble_sort_engine.sv @@
// top level of the bubble sort engine: sequencer, element count and output register
// depends on bse_pkg, bse_ram and bse_cmp_swap
`default_nettype none

// Collects a batch of signed 32-bit items (one per cycle while req_tready is high,
// the batch closed by req_tlast), keeps up to 64 of them in one ram and drops the
// rest, setting rsp_tuser on every result of such a batch. After the last item the
// batch is sorted ascending, stable, by bubble passes: each pass streams the ram
// through one compare-and-swap unit carrying the larger value forward, one entry
// per cycle through the single read port. The results then leave in order, each
// read from the ram, registered and held until rsp_tready takes it before the next
// is read, the final one marked by rsp_tlast. No input item is taken from the last
// item of a batch until its final result is accepted. No clearing pass follows reset.
module bubble_sort_engine (
   input  wire  logic                                clock,
   input  wire  logic                                reset,
   input  wire  logic                                req_tvalid,
   output logic                                      req_tready,
   input  wire  logic signed [bse_pkg::DATA_W-1:0]   req_tdata,   // [31:0] value
   input  wire  logic                                req_tlast,   // last
   output logic                                      rsp_tvalid,
   input  wire  logic                                rsp_tready,
   output logic signed [bse_pkg::DATA_W-1:0]         rsp_tdata,   // [31:0] sorted_value
   output logic                                      rsp_tlast,   // final_res
   output logic                                      rsp_tuser    // [0] dropped
);

   import bse_pkg::*;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     overflow_ff, overflow_in;
   logic [ADDR_W-1:0]        idx_ff, idx_in;
   logic [ADDR_W-1:0]        lim_ff, lim_in;
   logic signed [DATA_W-1:0] carry_ff, carry_in;
   logic signed [DATA_W-1:0] out_value_ff, out_value_in;
   logic                     out_last_ff, out_last_in;
   logic                     out_valid_ff, out_valid_in;

   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic [DATA_W-1:0]        wr_data;
   logic                     rd_en;
   logic [ADDR_W-1:0]        rd_addr;
   logic [DATA_W-1:0]        rd_data;
   logic signed [DATA_W-1:0] fetched;
   cmp_out_type              cmp;

   logic                     req_accept;
   logic                     has_room;
   logic [CNT_W-1:0]         new_count;
   logic [ADDR_W-1:0]        last_idx;

   bse_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign fetched = $signed(rd_data);

   bse_cmp_swap u_cmp (
      .carry   (carry_ff),
      .fetched (fetched),
      .result  (cmp)
   );

   assign req_tready = (state_ff == S_LOAD);
   assign req_accept = req_tvalid && req_tready;
   assign has_room   = count_ff < CNT_W'(MAX_ITEMS);
   assign new_count  = has_room ? count_ff + CNT_W'(1) : count_ff;
   assign last_idx   = ADDR_W'(count_ff - CNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      lim_ff       <= lim_in;
      carry_ff     <= carry_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      idx_in       = idx_ff;
      lim_in       = lim_ff;
      carry_in     = carry_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = carry_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;
      case (state_ff)
         S_LOAD: begin
            if (req_accept) begin
               count_in = new_count;
               if (has_room) begin
                  wr_en   = 1'b1;
                  wr_addr = ADDR_W'(count_ff);
                  wr_data = req_tdata;
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_tlast) begin
                  lim_in = ADDR_W'(new_count - CNT_W'(1));
                  idx_in = '0;
                  if (new_count > CNT_W'(1)) begin
                     state_in = S_PASS_INIT;
                  end else begin
                     state_in = S_EMIT_RD;
                  end
               end
            end
         end
         S_PASS_INIT: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            idx_in   = ADDR_W'(1);
            state_in = S_PASS_LOAD;
         end
         S_PASS_LOAD: begin
            carry_in = fetched;
            rd_en    = 1'b1;
            rd_addr  = idx_ff;
            state_in = S_PASS_RUN;
         end
         S_PASS_RUN: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff - ADDR_W'(1);
            wr_data  = cmp.lo;
            carry_in = cmp.hi;
            if (idx_ff == lim_ff) begin
               state_in = S_PASS_END;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff + ADDR_W'(1);
               idx_in   = idx_ff + ADDR_W'(1);
            end
         end
         S_PASS_END: begin
            wr_en   = 1'b1;
            wr_addr = lim_ff;
            wr_data = carry_ff;
            if (lim_ff == ADDR_W'(1)) begin
               idx_in   = '0;
               state_in = S_EMIT_RD;
            end else begin
               lim_in   = lim_ff - ADDR_W'(1);
               state_in = S_PASS_INIT;
            end
         end
         S_EMIT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff;
            state_in = S_EMIT_CAP;
         end
         S_EMIT_CAP: begin
            out_value_in = fetched;
            out_last_in  = (idx_ff == last_idx);
            out_valid_in = 1'b1;
            state_in     = S_EMIT_WAIT;
         end
         S_EMIT_WAIT: begin
            if (rsp_tready) begin
               out_valid_in = 1'b0;
               if (out_last_ff) begin
                  count_in    = '0;
                  overflow_in = 1'b0;
                  state_in    = S_LOAD;
               end else begin
                  idx_in   = idx_ff + ADDR_W'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_value_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = overflow_ff;

`ifndef SYNTHESIS
   a_no_load_while_emitting: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("input taken while a result is pending");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("element count beyond capacity");

   a_batch_end_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && count_ff == '0 && !rsp_tuser)
      else $error("batch state not cleared after final item");

   a_pass_index_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PASS_RUN |-> idx_ff <= lim_ff && idx_ff != '0)
      else $error("sort pass index out of range");

   a_overflow_only_full: assert property (@(posedge clock) disable iff (reset)
      $rose(overflow_ff) |-> count_ff == CNT_W'(MAX_ITEMS))
      else $error("overflow flagged with room left");
`endif

endmodule

`default_nettype wire

@@ sv/bse_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module bse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire  logic                     clock,
   input  wire  logic                     wr_en,
   input  wire  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  logic [WIDTH-1:0]         wr_data,
   input  wire  logic                     rd_en,
   input  wire  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic       [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/bse_cmp_swap.sv @@
// shared signed compare-and-swap unit of the bubble sort engine
// depends on bse_pkg
`default_nettype none

module bse_cmp_swap (
   input  wire  logic signed [bse_pkg::DATA_W-1:0] carry,
   input  wire  logic signed [bse_pkg::DATA_W-1:0] fetched,
   output bse_pkg::cmp_out_type                    result
);

   import bse_pkg::*;

   logic greater;

   // strict compare keeps equal values in place
   assign greater   = carry > fetched;
   assign result.lo = greater ? fetched : carry;
   assign result.hi = greater ? carry : fetched;

endmodule

`default_nettype wire

@@ sim/tb_bubble_sort_engine.sv @@
// self-checking testbench for bubble_sort_engine: streams signed batches, predicts the sorted
// output in a small scoreboard class and compares every result item field by field
// depends on bse_pkg and the bubble_sort_engine rtl
module tb_bubble_sort_engine;
   timeunit 1ns;
   timeprecision 1ps;

   import bse_pkg::*;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic                     final_res;
      logic                     dropped;
   } sorted_entry_type;

   class batch_sort_checker;
      logic signed [DATA_W-1:0] held [MAX_ITEMS];
      int unsigned              held_count;
      bit                       spilled;
      sorted_entry_type         sorted_due[$];
      int unsigned              mismatches;

      function new();
         held_count = 0;
         spilled    = 0;
         mismatches = 0;
      endfunction

      function void take_element(logic signed [DATA_W-1:0] value, bit last);
         int unsigned              p;
         int unsigned              k;
         logic signed [DATA_W-1:0] swap;
         sorted_entry_type         entry;
         if (held_count < MAX_ITEMS) begin
            held[held_count] = value;
            held_count++;
         end else begin
            spilled = 1'b1;
         end
         if (!last) return;
         for (p = 0; p + 1 < held_count; p++) begin
            for (k = 0; k + 1 < held_count - p; k++) begin
               if (held[k] > held[k+1]) begin
                  swap      = held[k];
                  held[k]   = held[k+1];
                  held[k+1] = swap;
               end
            end
         end
         for (k = 0; k < held_count; k++) begin
            entry.value     = held[k];
            entry.final_res = (k + 1 == held_count);
            entry.dropped   = spilled;
            sorted_due.push_back(entry);
         end
         held_count = 0;
         spilled    = 1'b0;
      endfunction

      task flag_mismatch(string what);
         mismatches++;
         if (mismatches <= 30) $display("[%0t] mismatch: %s", $realtime, what);
      endtask

      task check_sorted(logic signed [DATA_W-1:0] value, logic last, logic dropped);
         sorted_entry_type want;
         if (sorted_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected result item value %0d", value));
            return;
         end
         want = sorted_due.pop_front();
         if (value !== want.value)
            flag_mismatch($sformatf("sorted_value %0d, want %0d", value, want.value));
         if (last !== want.final_res)
            flag_mismatch($sformatf("final_res %b, want %b (value %0d)", last, want.final_res,
                                    want.value));
         if (dropped !== want.dropped)
            flag_mismatch($sformatf("dropped %b, want %b (value %0d)", dropped, want.dropped,
                                    want.value));
      endtask

      function int unsigned outstanding();
         return sorted_due.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic signed [DATA_W-1:0] req_tdata;   // [31:0] value
   logic                     req_tlast;   // last
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic signed [DATA_W-1:0] rsp_tdata;   // [31:0] sorted_value
   logic                     rsp_tlast;   // final_res
   logic                     rsp_tuser;   // [0] dropped

   batch_sort_checker sb = new();
   bit                calm = 1'b0;
   int                random_sent = 0;

   bubble_sort_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #2ms;
      $display("Verification failed");
      $finish;
   end

   // result side: random runs of ready and stall, always ready near the end
   initial begin
      int run_len;
      rsp_tready = 1'b0;
      forever begin
         if (calm) begin
            rsp_tready = 1'b1;
            @(negedge clock);
         end else begin
            run_len    = $urandom_range(1, 18);
            rsp_tready = ($urandom_range(0, 2) != 0);
            repeat (run_len) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_sorted(rsp_tdata, rsp_tlast, rsp_tuser);
   end

   function automatic logic signed [DATA_W-1:0] rand_element();
      case ($urandom_range(0, 7))
         0:       return 32'sh7fffffff;
         1:       return 32'sh80000000;
         2:       return $signed($urandom_range(0, 8)) - 4;
         default: return $urandom;
      endcase
   endfunction

   // starts and ends at a falling edge
   task automatic send_item(logic signed [DATA_W-1:0] value, bit last, bit may_idle);
      if (may_idle && !calm && $urandom_range(0, 2) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = value;
      req_tlast  = last;
      do @(posedge clock); while (!req_tready);
      sb.take_element(value, last);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic send_batch(int size);
      bit quiet;
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < size; i++) begin
         send_item(rand_element(), i == size - 1, !quiet);
         random_sent++;
         if (random_sent >= 250) calm = 1'b1;
      end
   endtask

   task automatic wait_drained();
      while (sb.outstanding() != 0) @(negedge clock);
   endtask

   initial begin
      logic signed [DATA_W-1:0] mix  [9];
      logic signed [DATA_W-1:0] desc [6];
      mix  = '{32'sh7fffffff, 32'sh80000000, 0, -1, 1, -1,
               32'sh7fffffff, 32'sh80000000, 5};
      desc = '{50, 40, 3, 3, -2, -100};
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // single-item batches at both extremes
      send_item(32'sh7fffffff, 1'b1, 1'b1);
      send_item(32'sh80000000, 1'b1, 1'b1);
      // extremes, zero and duplicates in one batch
      foreach (mix[i]) send_item(mix[i], i == 8, 1'b1);
      // reverse-ordered batch with a repeated value
      foreach (desc[i]) send_item(desc[i], i == 5, 1'b0);
      wait_drained();

      // full store, then overflow by one and by several
      send_batch(64);
      send_batch(65);
      wait_drained();
      send_batch(67);
      while (random_sent < 300) begin
         if ($urandom_range(0, 9) == 0)
            send_batch($urandom_range(60, 72));
         else
            send_batch($urandom_range(1, 12));
         if ($urandom_range(0, 5) == 0) wait_drained();
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
